@@ sv/complex_arithmetic_unit_assert.svh @@
// Assertion macros for the complex arithmetic unit.
// Used by files that include it inside a module with clk and rst in scope.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define CAU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Plain invariant checked on every clock edge outside reset.
`define CAU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

@@ sv/cau_pkg.sv @@
// Shared types, widths and opcodes of the complex arithmetic unit.
// No dependencies; imported by every module of the block.
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int MAG_W     = 64;                    // product-sum magnitude
  localparam int SUM_W     = MAG_W + 1;             // signed product sums
  localparam int QW        = 34;                    // quotient bits, one extra for rounding
  localparam int NUM_W     = MAG_W + FRAC_BITS + 1; // scaled dividend
  localparam int HI_W      = NUM_W - QW;
  localparam int RND_W     = SUM_W - FRAC_BITS;     // rounded magnitude
  localparam int LATENCY   = 6 + QW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] a_real;
    logic signed [DATA_W-1:0] a_imag;
    logic signed [DATA_W-1:0] b_real;
    logic signed [DATA_W-1:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_real;
    logic signed [DATA_W-1:0] res_imag;
    logic                     overflow;
    logic                     div_by_zero;
  } out_t;

  // One result part on its way through the divider chain. For add, subtract
  // and multiply rem simply carries the magnitude.
  typedef struct packed {
    logic             neg;
    logic             big;
    logic [MAG_W-1:0] rem;
    logic [QW-1:0]    sq;   // dividend bits shift out at the top, quotient in at the bottom
  } lane_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic             dz;
    logic [MAG_W-1:0] den;
    lane_t            re;
    lane_t            im;
  } div_beat_t;

endpackage

@@ sv/complex_arithmetic_unit.sv @@
// Complex arithmetic unit top level: add, subtract, multiply, divide in Q16.16.
// Depends on cau_pkg, cau_front, cau_div, cau_back and the assertion header.
//
// Usage:
//   Command channel: drive operand and raise start; the beat is taken on any
//   edge where start is high and busy is low. busy is high only during reset,
//   so one new beat can be taken every cycle.
//   Result channel: done pulses for one cycle with result; each start beat
//   gives exactly one result beat, in order.
//   Every opcode takes the same path: three front stages (products,
//   sums, sign/magnitude), one divider setup stage, 34 one-bit divider
//   stages and two back stages (rounding, saturation). Throughput is one
//   beat per cycle, set by the fully pipelined divider chain.
//   Divide by a zero-magnitude divisor returns zero with div_by_zero set.
//   Reset clears all valid bits; beats in flight are dropped.
//   The receiver cannot stall: results are presented once and must be taken.
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  operand,
  output logic done,
  output out_t result
);

  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  logic      accept;
  div_beat_t front_beat;
  div_beat_t div_beat;

  assign busy   = rst;
  assign accept = start && !busy;

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .operand  (operand),
    .beat     (front_beat)
  );

  cau_div u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (front_beat),
    .dout (div_beat)
  );

  cau_back u_back (
    .clk    (clk),
    .rst    (rst),
    .din    (div_beat),
    .done   (done),
    .result (result)
  );

  // Result views used by the checks
  logic re_at_end, im_at_end, res_clean;

  assign re_at_end = (result.res_real == SAT_POS) || (result.res_real == SAT_NEG);
  assign im_at_end = (result.res_imag == SAT_POS) || (result.res_imag == SAT_NEG);
  assign res_clean = (result.res_real == '0) && (result.res_imag == '0) && !result.overflow;

  // Checks
  `CAU_ASSERT_IMPLY(a_fixed_latency, accept, ##LATENCY done, "result beat missing")
  `CAU_ASSERT_IMPLY(a_dz_zero, done && result.div_by_zero, res_clean, "zero divisor result not clean")
  `CAU_ASSERT_IMPLY(a_ovf_ends, done && result.overflow, re_at_end || im_at_end, "overflow without saturated part")

endmodule

@@ sv/cau_front.sv @@
// Front end: six 32x32 products, product sums and sign/magnitude split.
// Three register stages; depends on cau_pkg.
module cau_front
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  in_t       operand,
  output div_beat_t beat
);

  // Stage 1: products and short sums
  logic                     v1;
  op_t                      op1;
  logic signed [MAG_W-1:0]  p_rr, p_ii, p_ri, p_ir, p_bbr, p_bbi;
  logic signed [DATA_W:0]   s_r, s_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    op1   <= op_t'(operand.opcode);
    p_rr  <= $signed(operand.a_real) * $signed(operand.b_real);
    p_ii  <= $signed(operand.a_imag) * $signed(operand.b_imag);
    p_ri  <= $signed(operand.a_real) * $signed(operand.b_imag);
    p_ir  <= $signed(operand.a_imag) * $signed(operand.b_real);
    p_bbr <= $signed(operand.b_real) * $signed(operand.b_real);
    p_bbi <= $signed(operand.b_imag) * $signed(operand.b_imag);
    if (op_t'(operand.opcode) == OP_SUB) begin
      s_r <= $signed({operand.a_real[DATA_W-1], operand.a_real})
           - $signed({operand.b_real[DATA_W-1], operand.b_real});
      s_i <= $signed({operand.a_imag[DATA_W-1], operand.a_imag})
           - $signed({operand.b_imag[DATA_W-1], operand.b_imag});
    end else begin
      s_r <= $signed({operand.a_real[DATA_W-1], operand.a_real})
           + $signed({operand.b_real[DATA_W-1], operand.b_real});
      s_i <= $signed({operand.a_imag[DATA_W-1], operand.a_imag})
           + $signed({operand.b_imag[DATA_W-1], operand.b_imag});
    end
  end

  // Stage 2: pick the signed sums for the operation
  logic                    v2;
  op_t                     op2;
  logic signed [SUM_W-1:0] sum_r, sum_i, sum_r_next, sum_i_next;
  logic [MAG_W-1:0]        den2;

  always_comb begin
    unique case (op1)
      OP_ADD, OP_SUB: begin
        sum_r_next = SUM_W'(s_r);
        sum_i_next = SUM_W'(s_i);
      end
      OP_MUL: begin
        sum_r_next = SUM_W'(p_rr) - SUM_W'(p_ii);
        sum_i_next = SUM_W'(p_ri) + SUM_W'(p_ir);
      end
      OP_DIV: begin
        sum_r_next = SUM_W'(p_rr) + SUM_W'(p_ii);
        sum_i_next = SUM_W'(p_ir) - SUM_W'(p_ri);
      end
      default: begin
        sum_r_next = '0;
        sum_i_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    op2   <= op1;
    sum_r <= sum_r_next;
    sum_i <= sum_i_next;
    den2  <= $unsigned(p_bbr) + $unsigned(p_bbi);
  end

  // Stage 3: sign and magnitude, zero-divisor detect
  logic [SUM_W-1:0] mag_r_w, mag_i_w;
  div_beat_t        beat_next;

  always_comb begin
    mag_r_w = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    mag_i_w = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    beat_next.valid  = v2 && !rst;
    beat_next.op     = op2;
    beat_next.dz     = (op2 == OP_DIV) && (den2 == '0);
    beat_next.den    = den2;
    beat_next.re.neg = sum_r[SUM_W-1];
    beat_next.re.big = 1'b0;
    beat_next.re.rem = mag_r_w[MAG_W-1:0];
    beat_next.re.sq  = '0;
    beat_next.im.neg = sum_i[SUM_W-1];
    beat_next.im.big = 1'b0;
    beat_next.im.rem = mag_i_w[MAG_W-1:0];
    beat_next.im.sq  = '0;
  end

  always_ff @(posedge clk) begin
    beat <= beat_next;
  end

endmodule

@@ sv/cau_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, both parts in parallel.
// Non-divide beats pass through unchanged; depends on cau_pkg.
module cau_div
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_beat_t din,
  output div_beat_t dout
);

  // Scale the dividend and catch quotients too large for the result
  function automatic lane_t prep_lane(lane_t l, logic [MAG_W-1:0] den);
    logic [NUM_W-1:0] num;
    logic [MAG_W-1:0] hi;
    lane_t            r;
    num    = {l.rem, {(FRAC_BITS+1){1'b0}}};
    hi     = {{(MAG_W-HI_W){1'b0}}, num[NUM_W-1:QW]};
    r      = l;
    r.big  = (hi >= den);
    r.rem  = r.big ? '0 : hi;
    r.sq   = num[QW-1:0];
    return r;
  endfunction

  // One compare-subtract step
  function automatic lane_t step_lane(lane_t l, logic [MAG_W-1:0] den);
    logic [MAG_W:0] t;
    logic           qb;
    lane_t          r;
    t     = {l.rem, l.sq[QW-1]};
    qb    = (t >= {1'b0, den});
    r     = l;
    r.rem = qb ? MAG_W'(t - {1'b0, den}) : t[MAG_W-1:0];
    r.sq  = {l.sq[QW-2:0], qb};
    return r;
  endfunction

  div_beat_t stg      [0:QW];
  div_beat_t stg_next [0:QW];
  div_beat_t pre_next;

  always_comb begin
    pre_next = din;
    if (din.op == OP_DIV) begin
      pre_next.re = prep_lane(din.re, din.den);
      pre_next.im = prep_lane(din.im, din.den);
    end
  end

  // Step chain: each stage works on the beat left by the one before
  always_comb begin
    stg_next[0]       = pre_next;
    stg_next[0].valid = pre_next.valid && !rst;
    for (int k = 0; k < QW; k++) begin
      stg_next[k+1] = stg[k];
      if (stg[k].op == OP_DIV) begin
        stg_next[k+1].re = step_lane(stg[k].re, stg[k].den);
        stg_next[k+1].im = step_lane(stg[k].im, stg[k].den);
      end
      stg_next[k+1].valid = stg[k].valid && !rst;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QW; k++) begin
      stg[k] <= stg_next[k];
    end
  end

  assign dout = stg[QW];

endmodule

@@ sv/cau_back.sv @@
// Back end: rounding to Q format, then saturation into the result register.
// Two register stages; depends on cau_pkg.
module cau_back
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_beat_t din,
  output logic      done,
  output out_t      result
);

  typedef struct packed {
    logic             neg;
    logic             big;
    logic [RND_W-1:0] mag;
  } rnd_lane_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_t;

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [RND_W-1:0] MAX_POS    = (RND_W'(1) << (DATA_W - 1)) - RND_W'(1);
  localparam logic [RND_W-1:0] MAX_NEG    = RND_W'(1) << (DATA_W - 1);
  localparam logic [DATA_W-1:0] POS_END   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_END   = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic rnd_lane_t round_lane(lane_t l, op_t op);
    logic [SUM_W-1:0] mul_sum;
    logic [QW:0]      div_sum;
    rnd_lane_t        r;
    mul_sum = {1'b0, l.rem} + ROUND_HALF;
    div_sum = {1'b0, l.sq} + (QW+1)'(1);
    r.big   = 1'b0;
    unique case (op)
      OP_ADD, OP_SUB: r.mag = l.rem[RND_W-1:0];
      OP_MUL:         r.mag = mul_sum[SUM_W-1:FRAC_BITS];
      OP_DIV: begin
        r.mag = RND_W'(div_sum[QW:1]);
        r.big = l.big;
      end
      default:        r.mag = '0;
    endcase
    r.neg = l.neg && (r.big || (r.mag != '0));
    return r;
  endfunction

  function automatic sat_t sat_lane(rnd_lane_t l);
    sat_t s;
    s.ovf = 1'b0;
    if (!l.neg && (l.big || (l.mag > MAX_POS))) begin
      s.val = POS_END;
      s.ovf = 1'b1;
    end else if (l.neg && (l.big || (l.mag > MAX_NEG))) begin
      s.val = NEG_END;
      s.ovf = 1'b1;
    end else if (l.neg) begin
      s.val = DATA_W'(-l.mag[DATA_W-1:0]);
    end else begin
      s.val = l.mag[DATA_W-1:0];
    end
    return s;
  endfunction

  // Stage 1: rounding
  logic      v1, dz1;
  rnd_lane_t r_re, r_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= din.valid;
    end
    dz1  <= din.dz;
    r_re <= round_lane(din.re, din.op);
    r_im <= round_lane(din.im, din.op);
  end

  // Stage 2: saturation and result register
  sat_t s_re, s_im;
  out_t result_next;

  always_comb begin
    s_re = sat_lane(r_re);
    s_im = sat_lane(r_im);
    if (dz1) begin
      result_next = '{res_real: '0, res_imag: '0, overflow: 1'b0, div_by_zero: 1'b1};
    end else begin
      result_next.res_real    = s_re.val;
      result_next.res_imag    = s_im.val;
      result_next.overflow    = s_re.ovf | s_im.ovf;
      result_next.div_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    result <= result_next;
  end

endmodule
